// File: design/spectrum_peak_decay_smoother_macros.svh
// Assertion macros used by the checker file of the spectrum smoother.
// Depends on nothing; the asserting module must have clock and reset in scope.
`ifndef SPECTRUM_PEAK_DECAY_SMOOTHER_MACROS_SVH
`define SPECTRUM_PEAK_DECAY_SMOOTHER_MACROS_SVH

`define SPDK_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`define SPDK_ASSERT(label, prop, msg) `SPDK_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// File: design/spdk_pkg.sv
// Shared widths, constants, types and the square root helper of the smoother.
// Used by every RTL file of the block but spdk_ram; depends on nothing.
package spdk_pkg;

   localparam int BIN_W       = 7;
   localparam int MAG_W       = 32;
   localparam int MASK_W      = 16;
   localparam int LEVEL_W     = 17;
   localparam int DECAY_CFG_W = 12;
   localparam int DB_CFG_W    = 16;
   localparam int DECAY_W     = 14;

   localparam int NUM_BINS_DEF   = 128;
   localparam int NUM_B_BINS_DEF = 128;
   localparam int BIN_SPAN       = 1 << BIN_W;

   localparam int SQ_STEPS = 16;
   localparam int LOG_LAT  = SQ_STEPS + 3;
   localparam int DEC_LAT  = 3;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DECAY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DECAY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_COEFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DB = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DB = 3'd4;

   localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = -17'sd25600;
   localparam logic [MASK_W-1:0] MASK_UNITY = 16'd32768;
   localparam logic signed [17:0] FLOOR_MARGIN = 18'sd10240;
   localparam logic signed [19:0] DB_PER_LOG2 = 20'sd394566;
   localparam logic [5:0] EXP_BIAS = 6'd24;

   localparam logic [DECAY_CFG_W-1:0] MIN_DECAY_RST = 12'd128;
   localparam logic [DECAY_CFG_W-1:0] MAX_DECAY_RST = 12'd512;
   localparam logic [MASK_W-1:0] MASK_COEFF_RST = 16'd9830;
   localparam logic signed [DB_CFG_W-1:0] MIN_DB_RST = -16'sd15360;
   localparam logic signed [DB_CFG_W-1:0] MAX_DB_RST = 16'sd0;

   typedef struct packed {
      logic [DECAY_CFG_W-1:0] min_decay;
      logic [DECAY_CFG_W-1:0] max_decay;
      logic [MASK_W-1:0] coeff;
      logic signed [DB_CFG_W-1:0] min_db;
      logic signed [DB_CFG_W-1:0] max_db;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic func;
      logic [BIN_W-1:0] bin;
      logic [MASK_W-1:0] mask;
   } ctl_type;

   typedef struct packed {
      logic valid;
      logic [BIN_W-1:0] bin;
      logic [LEVEL_W-1:0] level;
      logic [MASK_W-1:0] mask;
   } res_type;

   typedef struct packed {
      logic we_a;
      logic we_b;
      logic [BIN_W-1:0] bin;
      logic [LEVEL_W-1:0] level;
      logic [MASK_W-1:0] mask;
   } fwd_type;

   // Integer square root of a constant; evaluated only at elaboration.
   function automatic logic [15:0] isqrt_q32(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bit_v;
      rem = x;
      root = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= root + bit_v) begin
            rem = rem - (root + bit_v);
            root = (root >> 1) + bit_v;
         end else begin
            root = root >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return root[15:0];
   endfunction

endpackage

// File: design/spdk_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module spdk_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/spdk_log_db.sv
// Pipelined magnitude to dB converter: leading-one normalize, sixteen squaring
// stages for the log2 fraction, then scaling by 20*log10(2). Uses spdk_pkg.
module spdk_log_db import spdk_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic [MAG_W-1:0]          mag,
   output logic signed [LEVEL_W-1:0] db
);

   logic [MAG_W-1:0] code;
   logic [4:0]       msb;
   logic [MAG_W-1:0] norm;

   logic [4:0]       e_ff    [SQ_STEPS+1];
   logic [MAG_W-1:0] m_ff    [SQ_STEPS+1];
   logic [15:0]      frac_ff [SQ_STEPS+1];

   logic signed [21:0]        l_s;
   logic signed [41:0]        v_in;
   logic signed [41:0]        v_ff;
   logic signed [41:0]        rnd;
   logic signed [LEVEL_W-1:0] db_ff;

   always_comb begin
      code = (mag == '0) ? 32'd1 : mag;
      msb = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (code[i]) begin
            msb = 5'(i);
         end
      end
      norm = code << (5'd31 - msb);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff[0] <= msb;
         m_ff[0] <= norm;
         frac_ff[0] <= '0;
      end
   end

   for (genvar g = 1; g <= SQ_STEPS; g++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] tr;
      assign sq = 64'(m_ff[g-1]) * 64'(m_ff[g-1]);
      assign tr = sq[63:31];
      always_ff @(posedge clock) begin
         if (en) begin
            e_ff[g] <= e_ff[g-1];
            m_ff[g] <= tr[32] ? tr[32:1] : tr[31:0];
            frac_ff[g] <= {frac_ff[g-1][14:0], tr[32]};
         end
      end
   end

   assign l_s = signed'({({1'b0, e_ff[SQ_STEPS]} - EXP_BIAS), frac_ff[SQ_STEPS]});
   assign v_in = 42'(l_s) * 42'(DB_PER_LOG2);
   assign rnd = v_ff + 42'sd8388608;

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff <= v_in;
         db_ff <= LEVEL_W'(rnd >>> 24);
      end
   end

   assign db = db_ff;

endmodule

// File: design/spdk_decay.sv
// Decay per frame for a bin: square-root curve lookup, scale by the decay
// span and round. Three register stages. Uses spdk_pkg.
module spdk_decay import spdk_pkg::*; #(
   parameter int NUM_BINS = NUM_BINS_DEF
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [BIN_W-1:0]          bin,
   input  cfg_type                   cfg,
   output logic signed [DECAY_W-1:0] decay
);

   logic [15:0] sqrt_tab [BIN_SPAN];

   for (genvar g = 0; g < BIN_SPAN; g++) begin : g_tab
      localparam logic [63:0] QUOT = (64'(g) << 32) / 64'(NUM_BINS);
      assign sqrt_tab[g] = (g < NUM_BINS) ? isqrt_q32(QUOT) : 16'd0;
   end

   logic [15:0]               s_ff;
   logic signed [12:0]        diff;
   logic signed [29:0]        p_in;
   logic signed [29:0]        p_ff;
   logic signed [29:0]        rnd;
   logic signed [DECAY_W-1:0] add;
   logic signed [DECAY_W-1:0] decay_in;
   logic signed [DECAY_W-1:0] decay_ff;

   assign diff = signed'({1'b0, cfg.max_decay}) - signed'({1'b0, cfg.min_decay});
   assign p_in = 30'(diff) * 30'(signed'({1'b0, s_ff}));
   assign rnd = p_ff + 30'sd32768;
   assign add = DECAY_W'(rnd >>> 16);
   assign decay_in = signed'({2'b00, cfg.min_decay}) + add;

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= sqrt_tab[bin];
         p_ff <= p_in;
         decay_ff <= decay_in;
      end
   end

   assign decay = decay_ff;

endmodule

// File: design/spdk_update.sv
// State update stage: level and mask memories, clearing pass after reset,
// read-modify-write with forwarding of the previous write. Uses spdk_pkg, spdk_ram.
module spdk_update import spdk_pkg::*; #(
   parameter int NUM_BINS   = NUM_BINS_DEF,
   parameter int NUM_B_BINS = NUM_B_BINS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  ctl_type                   ctl_rd,
   input  ctl_type                   ctl_up,
   input  logic signed [LEVEL_W-1:0] db,
   input  logic signed [DECAY_W-1:0] decay,
   input  cfg_type                   cfg,
   output logic                      busy,
   output res_type                   res
);

   localparam int AW_A  = $clog2(NUM_BINS);
   localparam int AW_B  = $clog2(NUM_B_BINS);
   localparam int CLR_N = (NUM_BINS > NUM_B_BINS) ? NUM_BINS : NUM_B_BINS;
   localparam int CLR_W = $clog2(CLR_N + 1);
   localparam int WA    = LEVEL_W + MASK_W;

   logic [CLR_W-1:0] clr_cnt_ff;
   logic             clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CLR_W'(CLR_N - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign busy = clr_busy_ff;

   logic            in_a;
   logic            in_b;
   logic            up_we_a;
   logic            up_we_b;
   logic            we_a;
   logic            we_b;
   logic [AW_A-1:0] waddr_a;
   logic [AW_B-1:0] waddr_b;
   logic [WA-1:0]   wdata_a;
   logic [MASK_W-1:0] wdata_b;
   logic [WA-1:0]   rdata_a;
   logic [MASK_W-1:0] rdata_b;

   logic [LEVEL_W-1:0] new_level;
   logic [MASK_W-1:0]  new_mask;

   assign in_a = 32'(ctl_up.bin) < NUM_BINS;
   assign in_b = 32'(ctl_up.bin) < NUM_B_BINS;
   assign up_we_a = en && ctl_up.valid && !ctl_up.func && in_a;
   assign up_we_b = en && ctl_up.valid && ctl_up.func && in_b;

   assign we_a = clr_busy_ff ? (32'(clr_cnt_ff) < NUM_BINS) : up_we_a;
   assign we_b = clr_busy_ff ? (32'(clr_cnt_ff) < NUM_B_BINS) : up_we_b;
   assign waddr_a = clr_busy_ff ? AW_A'(clr_cnt_ff) : AW_A'(ctl_up.bin);
   assign waddr_b = clr_busy_ff ? AW_B'(clr_cnt_ff) : AW_B'(ctl_up.bin);
   assign wdata_a = clr_busy_ff ? {LEVEL_RESET, MASK_UNITY} : {new_level, new_mask};
   assign wdata_b = clr_busy_ff ? MASK_UNITY : new_mask;

   spdk_ram #(
      .WIDTH (WA),
      .DEPTH (NUM_BINS)
   ) u_ram_a (
      .clock (clock),
      .we    (we_a),
      .waddr (waddr_a),
      .wdata (wdata_a),
      .re    (en),
      .raddr (AW_A'(ctl_rd.bin)),
      .rdata (rdata_a)
   );

   spdk_ram #(
      .WIDTH (MASK_W),
      .DEPTH (NUM_B_BINS)
   ) u_ram_b (
      .clock (clock),
      .we    (we_b),
      .waddr (waddr_b),
      .wdata (wdata_b),
      .re    (en),
      .raddr (AW_B'(ctl_rd.bin)),
      .rdata (rdata_b)
   );

   // The write of the item one ahead lands on the same edge as this read.
   fwd_type fwd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff.we_a <= 1'b0;
         fwd_ff.we_b <= 1'b0;
      end else if (en) begin
         fwd_ff.we_a <= up_we_a;
         fwd_ff.we_b <= up_we_b;
         fwd_ff.bin <= ctl_up.bin;
         fwd_ff.level <= new_level;
         fwd_ff.mask <= new_mask;
      end
   end

   logic [MASK_W-1:0]  coeff_c;
   logic [MASK_W-1:0]  mask_c;
   logic [MASK_W-1:0]  cbar_ff;
   logic [31:0]        inc_ff;
   logic signed [17:0] lo_ff;
   logic signed [17:0] hi_ff;

   assign coeff_c = (cfg.coeff > MASK_UNITY) ? MASK_UNITY : cfg.coeff;
   assign mask_c = (ctl_rd.mask > MASK_UNITY) ? MASK_UNITY : ctl_rd.mask;

   always_ff @(posedge clock) begin
      cbar_ff <= MASK_UNITY - coeff_c;
      lo_ff <= 18'(cfg.min_db) - FLOOR_MARGIN;
      hi_ff <= 18'(cfg.max_db);
      if (en) begin
         inc_ff <= 32'(mask_c) * 32'(coeff_c);
      end
   end

   logic               hit_a;
   logic               hit_b;
   logic [LEVEL_W-1:0] old_level;
   logic [MASK_W-1:0]  old_mask;
   logic [32:0]        acc;
   logic signed [17:0] cur;
   logic signed [17:0] tgt;
   logic signed [17:0] dec;
   logic signed [17:0] lvl;

   assign hit_a = fwd_ff.we_a && (fwd_ff.bin == ctl_up.bin);
   assign hit_b = fwd_ff.we_b && (fwd_ff.bin == ctl_up.bin);

   always_comb begin
      old_level = hit_a ? fwd_ff.level : rdata_a[WA-1:MASK_W];
      if (ctl_up.func) begin
         old_mask = hit_b ? fwd_ff.mask : rdata_b;
      end else begin
         old_mask = hit_a ? fwd_ff.mask : rdata_a[MASK_W-1:0];
      end
      acc = 33'(old_mask) * 33'(cbar_ff) + 33'(inc_ff) + 33'd16384;
      new_mask = acc[30:15];

      cur = 18'(signed'(old_level));
      tgt = 18'(db);
      dec = 18'(decay);
      if (tgt > cur) begin
         lvl = tgt;
      end else begin
         lvl = cur - dec;
         if (lvl < tgt) begin
            lvl = tgt;
         end
      end
      if (lvl < lo_ff) begin
         lvl = lo_ff;
      end
      if (lvl > hi_ff) begin
         lvl = hi_ff;
      end
      new_level = lvl[LEVEL_W-1:0];
   end

   always_comb begin
      res.valid = ctl_up.valid;
      res.bin = ctl_up.bin;
      res.level = (!ctl_up.func && in_a) ? new_level : '0;
      if (ctl_up.func) begin
         res.mask = in_b ? new_mask : '0;
      end else begin
         res.mask = in_a ? new_mask : '0;
      end
   end

endmodule

// File: design/spectrum_peak_decay_smoother.sv
// Spectrum level peak hold with decay ballistics and mask smoothing, top level.
// Uses spdk_pkg, spdk_log_db, spdk_decay and spdk_update.
//
// Items enter on the req_ channel, one spectrum bin each: req_tuser selects
// stream A (level and mask) or stream B (mask only). Each accepted item yields
// exactly one item on the rsp_ channel, in order. The block takes one item per
// cycle while neither stalled nor clearing; every pipeline stage holds one item
// and the per-bin state memories are read one stage ahead of their write-back,
// with the previous write forwarded when the same bin follows directly.
// Registers are written on the csr_ channel, which is always ready; they are
// meant to change only while no item is in flight.
// After reset the level and mask memories are cleared, one entry per cycle;
// req_tready stays low during that pass.
// While rsp_tvalid is high and rsp_tready low the whole pipeline holds and
// req_tready is low; the waiting result stays unchanged.
module spectrum_peak_decay_smoother import spdk_pkg::*; #(
   parameter int NUM_BINS   = NUM_BINS_DEF,
   parameter int NUM_B_BINS = NUM_B_BINS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // bin [6:0], magnitude [38:7], mask_in [54:39], zero [55]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // func [0]
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // bin_out [6:0], level_db [23:7], mask_out [39:24]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MIN_DECAY: begin
               cfg_in.min_decay = csr_data[DECAY_CFG_W-1:0];
            end
            CSR_MAX_DECAY: begin
               cfg_in.max_decay = csr_data[DECAY_CFG_W-1:0];
            end
            CSR_MASK_COEFF: begin
               cfg_in.coeff = csr_data;
            end
            CSR_MIN_DB: begin
               cfg_in.min_db = signed'(csr_data);
            end
            CSR_MAX_DB: begin
               cfg_in.max_db = signed'(csr_data);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_decay <= MIN_DECAY_RST;
         cfg_ff.max_decay <= MAX_DECAY_RST;
         cfg_ff.coeff <= MASK_COEFF_RST;
         cfg_ff.min_db <= MIN_DB_RST;
         cfg_ff.max_db <= MAX_DB_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   logic    advance;
   logic    busy;
   logic    rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   ctl_type ctl_in;
   ctl_type ctl_ff [1:LOG_LAT];
   res_type res;

   logic signed [LEVEL_W-1:0] db;
   logic signed [DECAY_W-1:0] decay;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance && !busy;

   assign ctl_in.valid = req_tvalid && req_tready;
   assign ctl_in.func = req_tuser[0];
   assign ctl_in.bin = req_tdata[6:0];
   assign ctl_in.mask = req_tdata[54:39];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LOG_LAT; k++) begin
            ctl_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         ctl_ff[1] <= ctl_in;
         for (int k = 2; k <= LOG_LAT; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   spdk_log_db u_log_db (
      .clock (clock),
      .en    (advance),
      .mag   (req_tdata[38:7]),
      .db    (db)
   );

   spdk_decay #(
      .NUM_BINS (NUM_BINS)
   ) u_decay (
      .clock (clock),
      .en    (advance),
      .bin   (ctl_ff[LOG_LAT-DEC_LAT].bin),
      .cfg   (cfg_ff),
      .decay (decay)
   );

   spdk_update #(
      .NUM_BINS   (NUM_BINS),
      .NUM_B_BINS (NUM_B_BINS)
   ) u_update (
      .clock  (clock),
      .reset  (reset),
      .en     (advance),
      .ctl_rd (ctl_ff[LOG_LAT-1]),
      .ctl_up (ctl_ff[LOG_LAT]),
      .db     (db),
      .decay  (decay),
      .cfg    (cfg_ff),
      .busy   (busy),
      .res    (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {res.mask, res.level, res.bin};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// File: design/spdk_checker.sv
// Port-level checks of the spectrum smoother, bound to the top level.
// Uses spectrum_peak_decay_smoother_macros.svh.
`include "spectrum_peak_decay_smoother_macros.svh"

module spdk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   `SPDK_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "stalled result item changed")
   `SPDK_ASSERT(a_stall_blocks_input, rsp_tvalid && !rsp_tready |-> !req_tready, "item taken while output stalled")
   `SPDK_ASSERT(a_clear_after_reset, $past(reset) |-> !req_tready, "item taken during clearing pass")
   `SPDK_ASSERT(a_mask_range, rsp_tvalid |-> rsp_tdata[39:24] <= 16'd32768, "mask above unity")

endmodule

bind spectrum_peak_decay_smoother spdk_checker u_spdk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
